FILE: rtl/mbe_pkg.sv
`timescale 1ns / 1ps
package mbe_pkg;

  // Fixed-point format of every coordinate value.
  localparam int FRAC_BITS  = 28;
  localparam int COORD_BITS = 12;

  localparam int VAL_W   = 32;               // coordinate value width
  localparam int PROD_W  = 2 * VAL_W;        // full product width
  localparam int SQ_W    = PROD_W - FRAC_BITS; // a rounded square fits here
  localparam int SUM_W   = PROD_W + 2;       // headroom before saturation
  localparam int ITER_W  = 10;
  localparam int MAG_W   = 31;
  localparam int GEOM_W  = 13;
  localparam int SCALE_W = 31;
  localparam int D_W     = ((COORD_BITS > GEOM_W - 1) ? COORD_BITS : GEOM_W - 1) + 1;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ITER_W + MAG_W + 7) / 8) * 8;

  // Escape threshold |z|^2 > 4 in the fixed-point format.
  localparam logic [PROD_W-1:0] MAG_LIMIT = PROD_W'(4) << FRAC_BITS;

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32'h7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] SAT_MIN = {{(SUM_W - VAL_W + 1){1'b1}},
                                                 {(VAL_W - 1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ITER     = 3'd0,
    CFG_OFFSET_RE    = 3'd1,
    CFG_OFFSET_IM    = 3'd2,
    CFG_SCALE_RE     = 3'd3,
    CFG_SCALE_IM     = 3'd4,
    CFG_IMAGE_WIDTH  = 3'd5,
    CFG_IMAGE_HEIGHT = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [ITER_W-1:0]         max_iter;
    logic signed [VAL_W-1:0]   offset_re;
    logic signed [VAL_W-1:0]   offset_im;
    logic [SCALE_W-1:0]        scale_re;
    logic [SCALE_W-1:0]        scale_im;
    logic [GEOM_W-1:0]         image_width;
    logic [GEOM_W-1:0]         image_height;
  } cfg_t;

  typedef struct packed {
    logic [ITER_W-1:0] iter_count;
    logic              escaped;
    logic [MAG_W-1:0]  last_mag_sq;
  } res_t;

  // Clamp a widened sum to the signed 32-bit range.
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[VAL_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[VAL_W-1:0];
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/mbe_mul.sv
`timescale 1ns / 1ps
module mbe_mul
  import mbe_pkg::*;
(
  input  logic                     clk,
  input  logic signed [VAL_W-1:0]  op_a,
  input  logic signed [VAL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod_r
);

  logic signed [PROD_W-1:0] prod_nxt;

  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

FILE: rtl/mbe_seq.sv
`timescale 1ns / 1ps
module mbe_seq
  import mbe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  output logic                  idle,
  input  logic                  res_ready,
  output logic                  done,
  output res_t                  res
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_RE,
    S_MAP_IM,
    S_C_IM,
    S_SQ_X,
    S_SQ_Y,
    S_XY,
    S_UPD,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  logic [COORD_BITS-1:0]   px_r, py_r;
  logic signed [VAL_W-1:0] x_r, y_r, cre_r, cim_r;
  logic [SQ_W-1:0]         xx_r, yy_r;
  logic [ITER_W-1:0]       n_r, cnt_r;
  logic [MAG_W-1:0]        last_r;
  logic                    esc_r;

  logic signed [VAL_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [D_W-1:0]    dx, dy;
  logic signed [PROD_W-1:0] sh_sq, sh_xy;
  logic [SQ_W-1:0]          yy_now;
  logic [PROD_W-1:0]        mag;
  logic                     over, at_limit;
  logic signed [SUM_W-1:0]  c_sum, nx_sum, ny_sum;

  mbe_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  // Pixel offsets from the origin at the floor half of the image size.
  assign dx = $signed(D_W'(px_r) - D_W'(cfg.image_width[GEOM_W-1:1]));
  assign dy = $signed(D_W'(py_r) - D_W'(cfg.image_height[GEOM_W-1:1]));

  // Arithmetic right shift rounds toward minus infinity, as required.
  assign sh_sq  = prod_r >>> FRAC_BITS;
  assign sh_xy  = prod_r >>> (FRAC_BITS - 1);
  assign yy_now = sh_sq[SQ_W-1:0];
  assign mag    = PROD_W'(xx_r) + PROD_W'(yy_now);
  assign over     = mag > MAG_LIMIT;
  assign at_limit = n_r >= cfg.max_iter;

  always_comb begin
    op_a = x_r;
    op_b = x_r;
    case (state_r)
      S_MAP_RE: begin
        op_a = {{(VAL_W - D_W){dx[D_W-1]}}, dx};
        op_b = $signed({1'b0, cfg.scale_re});
      end
      S_MAP_IM: begin
        op_a = {{(VAL_W - D_W){dy[D_W-1]}}, dy};
        op_b = $signed({1'b0, cfg.scale_im});
      end
      S_SQ_Y: begin
        op_a = y_r;
        op_b = y_r;
      end
      S_XY: begin
        op_a = x_r;
        op_b = y_r;
      end
      default: begin
        op_a = x_r;
        op_b = x_r;
      end
    endcase
  end

  // The offset add serves both coordinates of c, in S_MAP_IM and S_C_IM; only the offset differs.
  always_comb begin
    if (state_r == S_MAP_IM) begin
      c_sum = SUM_W'(prod_r) + SUM_W'(cfg.offset_re);
    end else begin
      c_sum = SUM_W'(prod_r) + SUM_W'(cfg.offset_im);
    end
  end

  assign nx_sum = $signed(SUM_W'(xx_r)) - $signed(SUM_W'(yy_r)) + SUM_W'(cre_r);
  assign ny_sum = SUM_W'(sh_xy) + SUM_W'(cim_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (start) state_nxt = S_MAP_RE;
      S_MAP_RE: state_nxt = S_MAP_IM;
      S_MAP_IM: state_nxt = S_C_IM;
      S_C_IM:   state_nxt = S_SQ_Y;
      S_SQ_X:   state_nxt = S_SQ_Y;
      S_SQ_Y:   state_nxt = S_XY;
      S_XY:     state_nxt = (over || at_limit) ? S_FIN : S_UPD;
      S_UPD:    state_nxt = S_SQ_X;
      S_FIN:    if (res_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    case (state_r)
      S_IDLE: begin
        if (start) begin
          px_r   <= pixel_x;
          py_r   <= pixel_y;
          x_r    <= '0;
          y_r    <= '0;
          n_r    <= '0;
          last_r <= '0;
        end
      end
      S_MAP_IM: cre_r <= sat_val(c_sum);
      S_C_IM:   cim_r <= sat_val(c_sum);
      S_SQ_Y:   xx_r  <= sh_sq[SQ_W-1:0];
      S_XY: begin
        yy_r <= yy_now;
        if (over) begin
          esc_r <= 1'b1;
          cnt_r <= n_r - ITER_W'(1);
        end else if (at_limit) begin
          esc_r <= 1'b0;
          cnt_r <= cfg.max_iter;
        end else begin
          last_r <= mag[MAG_W-1:0];
        end
      end
      S_UPD: begin
        x_r <= sat_val(nx_sum);
        y_r <= sat_val(ny_sum);
        n_r <= n_r + ITER_W'(1);
      end
      default: ;
    endcase
  end

  assign idle = (state_r == S_IDLE);
  assign done = (state_r == S_FIN) && res_ready;

  assign res.iter_count  = cnt_r;
  assign res.escaped     = esc_r;
  assign res.last_mag_sq = last_r;

endmodule

FILE: rtl/mandelbrot_escape_time.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake             Payload
// in_      slave      in_tvalid/in_tready   pixel_x, pixel_y
// out_     master     out_tvalid/out_tready iter_count, last_mag_sq; escaped on tuser
// cfg_     write      cfg_we                cfg_addr selects the register, cfg_wdata
//
// An item's time from acceptance to result grows with n, the iterations
// done: one 32x32 multiplier does x*x, y*y and x*y in turn for each
// iteration, after S_MAP_RE, S_MAP_IM and S_C_IM map the pixel to c, and S_XY
// does the last magnitude check before S_FIN hands off to the output register.
// in_tready returns in the cycle after that hand-off, which waits while an unread
// result still sits in the output register. Reset is synchronous; it restores
// the register defaults and drops out_tvalid.
module mandelbrot_escape_time
  import mbe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,   // pixel_x, pixel_y
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,  // iter_count, last_mag_sq, zero fill
  output logic                   out_tuser,  // escaped
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t cfg_r;
  logic idle, done, res_ready, start;
  res_t res, res_r;
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_iter     <= ITER_W'(65);
      cfg_r.offset_re    <= '0;
      cfg_r.offset_im    <= '0;
      cfg_r.scale_re     <= SCALE_W'(1048576);
      cfg_r.scale_im     <= SCALE_W'(1398101);
      cfg_r.image_width  <= GEOM_W'(1024);
      cfg_r.image_height <= GEOM_W'(768);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MAX_ITER:     cfg_r.max_iter     <= cfg_wdata[ITER_W-1:0];
        CFG_OFFSET_RE:    cfg_r.offset_re    <= $signed(cfg_wdata[VAL_W-1:0]);
        CFG_OFFSET_IM:    cfg_r.offset_im    <= $signed(cfg_wdata[VAL_W-1:0]);
        CFG_SCALE_RE:     cfg_r.scale_re     <= cfg_wdata[SCALE_W-1:0];
        CFG_SCALE_IM:     cfg_r.scale_im     <= cfg_wdata[SCALE_W-1:0];
        CFG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_wdata[GEOM_W-1:0];
        CFG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_wdata[GEOM_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = idle;
  assign start     = in_tvalid && idle;
  assign res_ready = !out_valid_r || out_tready;

  mbe_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (start),
    .pixel_x   (in_tdata[COORD_BITS-1:0]),
    .pixel_y   (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .idle      (idle),
    .res_ready (res_ready),
    .done      (done),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (done) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({res_r.last_mag_sq, res_r.iter_count});
  assign out_tuser  = res_r.escaped;

endmodule

FILE: rtl/mbe_checker.sv
`timescale 1ns / 1ps
module mbe_checker
  import mbe_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  // A result held back by the sink must not change.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // The block is busy straight after it takes an item.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  // A new result cannot appear in the cycle after an item is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared too early");

  // The reported magnitude never exceeds the escape threshold of four.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[ITER_W+MAG_W-1:ITER_W] <= MAG_LIMIT[MAG_W-1:0])
    else $error("last magnitude above threshold");

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (.*);
